### hw/rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the index-to-character map of the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_URL_ALPHABET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE   = CFG_IDX_W'(1);

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // one queued character: a 6-bit index or a pad
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } b64e_code_t;

  // all characters one byte causes
  typedef struct packed {
    b64e_code_t [3:0] codes;
    logic [1:0]       last_pos;
    logic             msg_last;
  } b64e_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_q_status_t;

  function automatic logic [6:0] map_index(input logic [5:0] idx, input logic url);
    logic [6:0] ch;
    if (idx < 6'd26) begin
      ch = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      ch = 7'h61 + {1'b0, idx} - 7'd26;
    end else if (idx < 6'd62) begin
      ch = 7'h30 + {1'b0, idx} - 7'd52;
    end else if (idx == 6'd62) begin
      ch = url ? 7'h2D : 7'h2B;
    end else begin
      ch = url ? 7'h5F : 7'h2F;
    end
    return ch;
  endfunction

endpackage

### hw/rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Base64 encoder for a byte stream, standard or URL-safe alphabet, optional
// padding; config registers, front classifier, entry queue and char back end.
// ----------------------------------------------------------------------------
// Path: an accepted byte is written to the entry queue, then to the current-entry
//   register cur_r, and its characters leave through the output register.
// Throughput: one character per cycle while out_stall is low, set by the single output register;
//   a byte every cycle for bursts of one-char bytes, 4 chars per 3 bytes.
// Reset: synchronous, active low; clears phase, leftover bits, queue and
//   output valid; url_alphabet resets to 0 and pad_enable to 1.
module base64_stream_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [6:0]                     out_char,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [b64e_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import b64e_pkg::*;

  logic           url_alphabet_r;
  logic           pad_enable_r;
  logic           q_push, q_pop;
  b64e_entry_t    push_entry, pop_entry;
  b64e_q_status_t q_status;

  assign cfg_ready = 1'b1;

  // write config; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_alphabet_r <= 1'b0;
      pad_enable_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_URL_ALPHABET: url_alphabet_r <= cfg_data;
        CFG_PAD_ENABLE:   pad_enable_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .pad_enable   (pad_enable_r),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  b64e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .url_alphabet (url_alphabet_r),
    .q_status     (q_status),
    .q_entry      (pop_entry),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last)
  );

endmodule

### hw/rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the byte phase and leftover bits, and turns
// each byte into a queue entry of up to four character codes.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 pad_enable,
  input  b64e_pkg::b64e_q_status_t q_status,
  output logic                 q_push,
  output b64e_pkg::b64e_entry_t q_entry
);
  import b64e_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_entry          = '0;
    q_entry.msg_last = in_last_byte;
    phase_nxt        = phase_r;
    left_nxt         = left_r;
    case (phase_r)
      2'd1: begin
        q_entry.codes[0].idx = {left_r[1:0], in_data_byte[7:4]};
        q_entry.codes[1].idx = {in_data_byte[3:0], 2'b00};
        q_entry.codes[2].pad = 1'b1;
        q_entry.last_pos     = in_last_byte ? (pad_enable ? 2'd2 : 2'd1) : 2'd0;
        phase_nxt            = 2'd2;
        left_nxt             = in_data_byte[3:0];
      end
      2'd2: begin
        q_entry.codes[0].idx = {left_r, in_data_byte[7:6]};
        q_entry.codes[1].idx = in_data_byte[5:0];
        q_entry.last_pos     = 2'd1;
        phase_nxt            = 2'd0;
        left_nxt             = 4'd0;
      end
      default: begin
        q_entry.codes[0].idx = in_data_byte[7:2];
        q_entry.codes[1].idx = {in_data_byte[1:0], 4'b0000};
        q_entry.codes[2].pad = 1'b1;
        q_entry.codes[3].pad = 1'b1;
        q_entry.last_pos     = in_last_byte ? (pad_enable ? 2'd3 : 2'd1) : 2'd0;
        phase_nxt            = 2'd1;
        left_nxt             = {2'b00, in_data_byte[1:0]};
      end
    endcase
    // end of message: start the next one on a fresh group
    if (in_last_byte) begin
      phase_nxt = 2'd0;
      left_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

### hw/rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short FIFO of byte entries between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  b64e_pkg::b64e_entry_t   push_entry,
  input  logic                    pop,
  output b64e_pkg::b64e_entry_t   pop_entry,
  output b64e_pkg::b64e_q_status_t status
);
  import b64e_pkg::*;

  b64e_entry_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign status.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_entry    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes byte entries from the queue and emits one character per cycle,
// unless out_stall holds it, through the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     url_alphabet,
  input  b64e_pkg::b64e_q_status_t q_status,
  input  b64e_pkg::b64e_entry_t    q_entry,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [6:0]               out_char,
  output logic                     out_last
);
  import b64e_pkg::*;

  b64e_entry_t cur_r;
  logic        cur_valid_r;
  logic [1:0]  pos_r;
  logic        out_valid_r;
  logic [6:0]  out_char_r, char_nxt;
  logic        out_last_r;
  logic        can_load, adv, fin;
  b64e_code_t  code;

  assign can_load = !out_valid_r || !out_stall;
  assign adv      = cur_valid_r && can_load;
  assign fin      = adv && (pos_r == cur_r.last_pos);
  assign q_pop    = !q_status.empty && (!cur_valid_r || fin);

  assign code     = cur_r.codes[pos_r];
  assign char_nxt = code.pad ? PAD_CHAR : map_index(code.idx, url_alphabet);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (adv) begin
      out_char_r <= char_nxt;
      out_last_r <= cur_r.msg_last && (pos_r == cur_r.last_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        pos_r       <= 2'd0;
      end else begin
        if (fin) begin
          cur_valid_r <= 1'b0;
        end
        if (adv) begin
          pos_r <= pos_r + 1'b1;
        end
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (can_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (pos_r <= cur_r.last_pos))
    else $error("character position past end of entry");

  a_first_not_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && pos_r == 2'd0) |=> (out_char_r != PAD_CHAR))
    else $error("pad emitted as first character of a byte");

  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> (!out_valid_r && !cur_valid_r))
    else $error("output not idle after reset");

endmodule
